// ===== rtl/euler_vector_rotation_core_macros.svh =====
// Assertion macros shared by the Euler vector rotation core.
`ifndef EULER_VECTOR_ROTATION_CORE_MACROS_SVH
`define EULER_VECTOR_ROTATION_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EVR_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("evr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EVR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("evr: next-cycle check failed");

`endif

// ===== rtl/evr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers of the Euler vector rotation core.
package evr_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COORD_BITS = 32;
  localparam int WIDE_BITS  = COORD_BITS + 2;

  localparam int FRAC_W = 30;
  localparam int TRIG_W = 32;
  localparam int T_W    = FRAC_W + 1;
  localparam int X_W    = 31;
  localparam int X2_W   = 32;
  localparam int RES_W  = ANGLE_BITS - 2;
  localparam int PIH_W  = 41;
  localparam int X_SHIFT = ANGLE_BITS - 2 + 10;

  localparam logic [PIH_W-1:0] PIH_Q40  = 41'h1921FB54442;
  localparam logic [T_W-1:0]   TRIG_ONE = {1'b1, {FRAC_W{1'b0}}};

  localparam int NSTEPS   = 8;
  localparam int TRIG_LAT = 2 + 3 * NSTEPS + 2;

  // Series divisors, highest term first. The cosine series has one term fewer,
  // so its first step passes its value through.
  localparam int SIN_DIV [NSTEPS] = '{272, 210, 156, 110, 72, 42, 20, 6};
  localparam int COS_DIV [NSTEPS] = '{1, 240, 182, 132, 90, 56, 30, 12};

  typedef logic signed [TRIG_W-1:0]    trig_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  function automatic int evr_div_shift(int d);
    return 31 + $clog2(d);
  endfunction

endpackage

// ===== rtl/evr_trig.sv =====
`timescale 1ns / 1ps
// Pipelined sine and cosine of one binary angle, signed Q30 outputs.
module evr_trig import evr_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output trig_t                 sin_val,
  output trig_t                 cos_val
);

  logic [RES_W+PIH_W-1:0] xprod;
  logic [X_W-1:0]         x0;
  quad_t                  quad0;
  logic [2*X_W-1:0]       x2prod;

  logic [X_W-1:0]  xs  [NSTEPS+1];
  logic [X2_W-1:0] x2s [NSTEPS+1];
  quad_t           qs  [NSTEPS+1];
  logic [T_W-1:0]  ts  [NSTEPS+1];
  logic [T_W-1:0]  tc  [NSTEPS+1];

  assign xprod  = angle[RES_W-1:0] * PIH_Q40;
  assign x2prod = x0 * x0;

  always_ff @(posedge clk) begin
    if (en) begin
      x0     <= xprod[X_SHIFT +: X_W];
      quad0  <= quad_t'(angle[ANGLE_BITS-1 -: 2]);
      xs[0]  <= x0;
      x2s[0] <= x2prod[FRAC_W +: X2_W];
      qs[0]  <= quad0;
      ts[0]  <= TRIG_ONE;
      tc[0]  <= TRIG_ONE;
    end
  end

  for (genvar j = 0; j < NSTEPS; j++) begin : g_step
    localparam int SDIV = SIN_DIV[j];
    localparam int SSH  = evr_div_shift(SDIV);
    localparam logic [31:0] SREC = 32'((64'd1 << SSH) / SDIV);
    localparam logic [X2_W-1:0] SDIV_V = X2_W'(SDIV);

    logic [X2_W+T_W-1:0] pa_s, pa_c;
    logic [X_W-1:0]      xa, xb;
    logic [X2_W-1:0]     x2a, x2b;
    quad_t               qa, qb;
    logic [T_W-1:0]      tca, tcb;
    logic [X2_W-1:0]     pb_s, pb_c;
    logic [63:0]         mb_s, mb_c;
    logic [X2_W-1:0]     q0_s, rem_s, quo_s;
    logic [T_W-1:0]      tn_s, tn_c;

    always_ff @(posedge clk) begin
      if (en) begin
        pa_s <= x2s[j] * ts[j];
        pa_c <= x2s[j] * tc[j];
        xa   <= xs[j];
        x2a  <= x2s[j];
        qa   <= qs[j];
        tca  <= tc[j];
        pb_s <= pa_s[FRAC_W +: X2_W];
        pb_c <= pa_c[FRAC_W +: X2_W];
        mb_s <= pa_s[FRAC_W +: X2_W] * SREC;
        xb   <= xa;
        x2b  <= x2a;
        qb   <= qa;
        tcb  <= tca;
        xs[j+1]  <= xb;
        x2s[j+1] <= x2b;
        qs[j+1]  <= qb;
        ts[j+1]  <= tn_s;
        tc[j+1]  <= tn_c;
      end
    end

    always_comb begin
      q0_s  = X2_W'(mb_s >> SSH);
      rem_s = pb_s - X2_W'(q0_s * SDIV_V);
      quo_s = q0_s + {{(X2_W-1){1'b0}}, (rem_s >= SDIV_V)};
      tn_s  = TRIG_ONE - quo_s[T_W-1:0];
    end

    if (j == 0) begin : g_cpass
      assign tn_c = tcb;
      always_ff @(posedge clk) begin
        if (en) begin
          mb_c <= '0;
        end
      end
    end else begin : g_cdiv
      localparam int CDIV = COS_DIV[j];
      localparam int CSH  = evr_div_shift(CDIV);
      localparam logic [31:0] CREC = 32'((64'd1 << CSH) / CDIV);
      localparam logic [X2_W-1:0] CDIV_V = X2_W'(CDIV);

      logic [X2_W-1:0] q0_c, rem_c, quo_c;

      always_ff @(posedge clk) begin
        if (en) begin
          mb_c <= pa_c[FRAC_W +: X2_W] * CREC;
        end
      end

      always_comb begin
        q0_c  = X2_W'(mb_c >> CSH);
        rem_c = pb_c - X2_W'(q0_c * CDIV_V);
        quo_c = q0_c + {{(X2_W-1){1'b0}}, (rem_c >= CDIV_V)};
        tn_c  = TRIG_ONE - quo_c[T_W-1:0];
      end
    end
  end

  logic [2*X_W-1:0]      fs;
  logic [X2_W+T_W-1:0]   fc;
  quad_t                 fq;
  logic [31:0]           sraw;
  logic [X2_W:0]         craw;
  logic signed [X2_W+1:0] cdiff;
  logic [T_W-1:0]        spos, cpos;
  trig_t                 sp, cp, sin_next, cos_next;

  always_ff @(posedge clk) begin
    if (en) begin
      fs      <= xs[NSTEPS] * ts[NSTEPS];
      fc      <= x2s[NSTEPS] * tc[NSTEPS];
      fq      <= qs[NSTEPS];
      sin_val <= sin_next;
      cos_val <= cos_next;
    end
  end

  always_comb begin
    sraw  = fs[FRAC_W +: 32];
    spos  = (sraw > 32'(TRIG_ONE)) ? TRIG_ONE : sraw[T_W-1:0];
    craw  = fc[FRAC_W +: X2_W+1];
    cdiff = $signed({3'b000, TRIG_ONE}) - $signed({2'b00, craw[X2_W:1]});
    cpos  = cdiff[X2_W+1] ? '0 : cdiff[T_W-1:0];
    sp    = {1'b0, spos};
    cp    = {1'b0, cpos};
    unique case (fq)
      QUAD_0: begin
        sin_next = sp;
        cos_next = cp;
      end
      QUAD_1: begin
        sin_next = cp;
        cos_next = -sp;
      end
      QUAD_2: begin
        sin_next = -sp;
        cos_next = -cp;
      end
      QUAD_3: begin
        sin_next = -cp;
        cos_next = sp;
      end
      default: begin
        sin_next = sp;
        cos_next = cp;
      end
    endcase
  end

endmodule

// ===== rtl/evr_rot.sv =====
`timescale 1ns / 1ps
// Two-stage plane rotation of a coordinate pair by a sine and cosine.
module evr_rot import evr_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  wide_t p_in,
  input  wide_t q_in,
  input  trig_t s,
  input  trig_t c,
  output wide_t p_out,
  output wide_t q_out
);

  localparam int HI_W = WIDE_BITS - 16 + TRIG_W;
  localparam int LO_W = 17 + TRIG_W;
  localparam logic signed [LO_W-1:0] LO_ROUND = LO_W'(1 << 29);

  typedef struct packed {
    logic signed [HI_W-1:0] hi;
    logic signed [LO_W-1:0] lo;
  } part_t;

  // The vector is split into a signed high part and an unsigned low 16-bit part.
  function automatic part_t split_mul(wide_t v, trig_t t);
    part_t r;
    logic signed [WIDE_BITS-17:0] vh;
    logic signed [16:0] vl;
    vh = $signed(v[WIDE_BITS-1:16]);
    vl = $signed({1'b0, v[15:0]});
    r.hi = vh * t;
    r.lo = vl * t + LO_ROUND;
    return r;
  endfunction

  function automatic wide_t join_part(part_t m);
    logic signed [HI_W:0] sum;
    sum = m.hi + (m.lo >>> 16);
    return WIDE_BITS'(sum >>> 14);
  endfunction

  part_t pc_r, qs_r, ps_r, qc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r  <= split_mul(p_in, c);
      qs_r  <= split_mul(q_in, s);
      ps_r  <= split_mul(p_in, s);
      qc_r  <= split_mul(q_in, c);
      p_out <= join_part(pc_r) - join_part(qs_r);
      q_out <= join_part(ps_r) + join_part(qc_r);
    end
  end

endmodule

// ===== rtl/euler_vector_rotation_core.sv =====
`timescale 1ns / 1ps
// Top level of the Euler vector rotation core: rotates a vector by Rz*Ry*Rx.
//
//   word     | handshake            | contents
//   ---------+----------------------+------------------------------------------
//   input    | vec_valid, vec_ready | pitch, yaw, roll angles and vec_x/y/z
//   output   | rot_valid, rot_ready | rot_x, rot_y, rot_z, saturated Q16.16
//
// One word enters per cycle unless rot_valid is high and rot_ready low.
// The pipeline consists of the sine and cosine series, three multiply stages per
// term, followed by three two-stage plane rotations and an output register.
// Reset clears only the valid bits of the pipeline.
// When rot_valid is high and rot_ready low, the whole pipeline holds.
`include "euler_vector_rotation_core_macros.svh"
module euler_vector_rotation_core import evr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         vec_valid,
  output logic                         vec_ready,
  input  logic signed [ANGLE_BITS-1:0] pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] yaw_angle,
  input  logic signed [ANGLE_BITS-1:0] roll_angle,
  input  logic signed [COORD_BITS-1:0] vec_x,
  input  logic signed [COORD_BITS-1:0] vec_y,
  input  logic signed [COORD_BITS-1:0] vec_z,
  output logic                         rot_valid,
  input  logic                         rot_ready,
  output logic signed [COORD_BITS-1:0] rot_x,
  output logic signed [COORD_BITS-1:0] rot_y,
  output logic signed [COORD_BITS-1:0] rot_z
);

  localparam int LAT = TRIG_LAT + 7;

  logic           en;
  logic [LAT-1:0] vld;

  assign rot_valid = vld[LAT-1];
  assign en        = !rot_valid || rot_ready;
  assign vec_ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], vec_valid};
    end
  end

  trig_t pitch_s, pitch_c, yaw_s, yaw_c, roll_s, roll_c;

  evr_trig u_trig_pitch (
    .clk     (clk),
    .en      (en),
    .angle   (pitch_angle),
    .sin_val (pitch_s),
    .cos_val (pitch_c)
  );

  evr_trig u_trig_yaw (
    .clk     (clk),
    .en      (en),
    .angle   (yaw_angle),
    .sin_val (yaw_s),
    .cos_val (yaw_c)
  );

  evr_trig u_trig_roll (
    .clk     (clk),
    .en      (en),
    .angle   (roll_angle),
    .sin_val (roll_s),
    .cos_val (roll_c)
  );

  function automatic logic signed [COORD_BITS-1:0] sat_coord(wide_t v);
    if (v[WIDE_BITS-1:COORD_BITS-1] == '0 || v[WIDE_BITS-1:COORD_BITS-1] == '1) begin
      return v[COORD_BITS-1:0];
    end else if (v[WIDE_BITS-1]) begin
      return {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

  wide_t dx [TRIG_LAT];
  wide_t dy [TRIG_LAT];
  wide_t dz [TRIG_LAT];
  trig_t yaw_sd  [2];
  trig_t yaw_cd  [2];
  trig_t roll_sd [4];
  trig_t roll_cd [4];
  wide_t x1d [2];
  wide_t y2d [2];
  wide_t z3d [2];

  wide_t y1, z1, z2, x2, x3, y3;

  always_ff @(posedge clk) begin
    if (en) begin
      dx[0] <= WIDE_BITS'(vec_x);
      dy[0] <= WIDE_BITS'(vec_y);
      dz[0] <= WIDE_BITS'(vec_z);
      for (int i = 1; i < TRIG_LAT; i++) begin
        dx[i] <= dx[i-1];
        dy[i] <= dy[i-1];
        dz[i] <= dz[i-1];
      end
      yaw_sd[0]  <= yaw_s;
      yaw_cd[0]  <= yaw_c;
      yaw_sd[1]  <= yaw_sd[0];
      yaw_cd[1]  <= yaw_cd[0];
      roll_sd[0] <= roll_s;
      roll_cd[0] <= roll_c;
      for (int i = 1; i < 4; i++) begin
        roll_sd[i] <= roll_sd[i-1];
        roll_cd[i] <= roll_cd[i-1];
      end
      x1d[0] <= dx[TRIG_LAT-1];
      x1d[1] <= x1d[0];
      y2d[0] <= y1;
      y2d[1] <= y2d[0];
      z3d[0] <= z2;
      z3d[1] <= z3d[0];
      rot_x  <= sat_coord(x3);
      rot_y  <= sat_coord(y3);
      rot_z  <= sat_coord(z3d[1]);
    end
  end

  evr_rot u_rot_pitch (
    .clk   (clk),
    .en    (en),
    .p_in  (dy[TRIG_LAT-1]),
    .q_in  (dz[TRIG_LAT-1]),
    .s     (pitch_s),
    .c     (pitch_c),
    .p_out (y1),
    .q_out (z1)
  );

  evr_rot u_rot_yaw (
    .clk   (clk),
    .en    (en),
    .p_in  (z1),
    .q_in  (x1d[1]),
    .s     (yaw_sd[1]),
    .c     (yaw_cd[1]),
    .p_out (z2),
    .q_out (x2)
  );

  evr_rot u_rot_roll (
    .clk   (clk),
    .en    (en),
    .p_in  (x2),
    .q_in  (y2d[1]),
    .s     (roll_sd[3]),
    .c     (roll_cd[3]),
    .p_out (x3),
    .q_out (y3)
  );

  `EVR_ASSERT_NEXT(a_stall_holds, rot_valid && !rot_ready, $stable(vld))
  `EVR_ASSERT_NEXT(a_accept_enters, vec_valid && vec_ready, vld[0])
  `EVR_ASSERT_NEXT(a_bubble_drains, rot_valid && rot_ready && !vld[LAT-2], !rot_valid)
  `EVR_ASSERT_SAME(a_ready_when_empty, !rot_valid, vec_ready)

endmodule

// ===== tb/euler_vector_rotation_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the Euler vector rotation core, with its own rotation predictor.
module euler_vector_rotation_core_tb import evr_pkg::*;;

  localparam int LATENCY = 35;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 530;
  localparam logic signed [63:0] Q_ONE = 64'sd1 << 30;
  localparam logic signed [63:0] PIH = 64'sh1921FB54442;
  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] pitch;
    logic signed [ANGLE_BITS-1:0] yaw;
    logic signed [ANGLE_BITS-1:0] roll;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } vec_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } rot_word_t;

  typedef struct packed {
    vec_word_t  stim;
    logic       known;
    rot_word_t  result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vec_valid = 1'b0;
  logic vec_ready;
  logic signed [ANGLE_BITS-1:0] pitch_angle = '0;
  logic signed [ANGLE_BITS-1:0] yaw_angle = '0;
  logic signed [ANGLE_BITS-1:0] roll_angle = '0;
  logic signed [COORD_BITS-1:0] vec_x = '0;
  logic signed [COORD_BITS-1:0] vec_y = '0;
  logic signed [COORD_BITS-1:0] vec_z = '0;
  logic rot_valid;
  logic rot_ready = 1'b0;
  logic signed [COORD_BITS-1:0] rot_x;
  logic signed [COORD_BITS-1:0] rot_y;
  logic signed [COORD_BITS-1:0] rot_z;

  rot_word_t pending_rots[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit stimulus_done = 1'b0;

  euler_vector_rotation_core i_dut (
    .clk(clk), .rst(rst),
    .vec_valid(vec_valid), .vec_ready(vec_ready),
    .pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .rot_valid(rot_valid), .rot_ready(rot_ready),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [63:0] shr_floor(logic signed [63:0] v, int n);
    return v >>> n;
  endfunction

  // Sine and cosine of a binary angle, signed Q30.
  function automatic void angle_sincos(logic [ANGLE_BITS-1:0] ang,
                                       output logic signed [63:0] sn,
                                       output logic signed [63:0] cs);
    logic [1:0] quad;
    logic [63:0] r, x, x2, t, s, c, q;
    quad = ang[ANGLE_BITS-1 -: 2];
    r = 64'(ang[ANGLE_BITS-3:0]);
    x = (r * 64'(PIH)) >> (ANGLE_BITS - 2 + 10);
    x2 = (x * x) >> 30;
    t = 64'(Q_ONE);
    for (int k = 8; k >= 1; k--)
      t = 64'(Q_ONE) - ((x2 * t) >> 30) / 64'((2 * k) * (2 * k + 1));
    s = (x * t) >> 30;
    if (s > 64'(Q_ONE)) s = 64'(Q_ONE);
    t = 64'(Q_ONE);
    for (int k = 8; k >= 2; k--)
      t = 64'(Q_ONE) - ((x2 * t) >> 30) / 64'((2 * k - 1) * (2 * k));
    q = (x2 * t) >> 30;
    c = 64'(Q_ONE - $signed(q) / 2);
    if ($signed(c) < 0) c = 0;
    if ($signed(c) > Q_ONE) c = 64'(Q_ONE);
    case (quad_t'(quad))
      QUAD_0: begin sn = s; cs = c; end
      QUAD_1: begin sn = c; cs = -$signed(s); end
      QUAD_2: begin sn = -$signed(s); cs = -$signed(c); end
      default: begin sn = -$signed(c); cs = s; end
    endcase
  endfunction

  function automatic logic signed [63:0] scale_q30(logic signed [63:0] v,
                                                   logic signed [63:0] t);
    logic signed [63:0] vh, vl, hi, lo;
    vh = shr_floor(v, 16);
    vl = v & 64'sh0000_0000_0000_FFFF;
    hi = vh * t;
    lo = vl * t + (64'sd1 <<< 29);
    return shr_floor(hi + shr_floor(lo, 16), 14);
  endfunction

  function automatic void plane_turn(inout logic signed [63:0] p, inout logic signed [63:0] q,
                                     input logic signed [63:0] s, input logic signed [63:0] c);
    logic signed [63:0] np, nq;
    np = scale_q30(p, c) - scale_q30(q, s);
    nq = scale_q30(p, s) + scale_q30(q, c);
    p = np;
    q = nq;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(logic signed [63:0] v);
    if (v > 64'(CMAX)) return CMAX;
    if (v < 64'(CMIN)) return CMIN;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic rot_word_t rotate_euler(vec_word_t w);
    logic signed [63:0] x, y, z, s, c;
    rot_word_t res;
    x = 64'(w.x);
    y = 64'(w.y);
    z = 64'(w.z);
    angle_sincos(w.pitch, s, c);
    plane_turn(y, z, s, c);
    angle_sincos(w.yaw, s, c);
    plane_turn(z, x, s, c);
    angle_sincos(w.roll, s, c);
    plane_turn(x, y, s, c);
    res.x = clamp_coord(x);
    res.y = clamp_coord(y);
    res.z = clamp_coord(z);
    return res;
  endfunction

  function automatic vec_word_t random_word();
    vec_word_t w;
    w.pitch = ANGLE_BITS'($urandom);
    w.yaw = ANGLE_BITS'($urandom);
    w.roll = ANGLE_BITS'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        w.x = $urandom;
        w.y = $urandom;
        w.z = $urandom;
      end
      1: begin
        w.x = $signed($urandom) >>> $urandom_range(0, 31);
        w.y = $signed($urandom) >>> $urandom_range(0, 31);
        w.z = $signed($urandom) >>> $urandom_range(0, 31);
      end
      2: begin
        w.x = $urandom_range(0, 1) ? CMAX : CMIN;
        w.y = $urandom_range(0, 1) ? CMAX - $urandom_range(0, 255) : CMIN + $urandom_range(0, 255);
        w.z = $urandom_range(0, 1) ? CMAX : CMIN;
      end
      default: begin
        w.x = $signed(32'($urandom_range(0, 131071))) - 65536;
        w.y = $signed(32'($urandom_range(0, 131071))) - 65536;
        w.z = $signed(32'($urandom_range(0, 131071))) - 65536;
        if ($urandom_range(0, 1)) w.pitch = 16'($urandom_range(0, 3)) << 14;
      end
    endcase
    return w;
  endfunction

  task automatic send_word(vec_word_t w, logic known, rot_word_t result);
    pitch_angle <= w.pitch;
    yaw_angle <= w.yaw;
    roll_angle <= w.roll;
    vec_x <= w.x;
    vec_y <= w.y;
    vec_z <= w.z;
    vec_valid <= 1'b1;
    do @(posedge clk); while (!vec_ready);
    pending_rots.push_back(known ? result : rotate_euler(w));
    @(negedge clk);
  endtask

  task automatic take_break();
    vec_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  stim_row_t directed_rows[] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 32'sd65536, 32'sd131072, -32'sd196608}, 1'b1,
      '{32'sd65536, 32'sd131072, -32'sd196608}},
    '{'{16'sd0, 16'sd0, 16'sd0, CMAX, CMIN, 32'sd0}, 1'b1, '{CMAX, CMIN, 32'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 32'sd0}},
    '{'{16'sd16384, 16'sd0, 16'sd0, 32'sd0, 32'sd65536, 32'sd0}, 1'b0, '0},
    '{'{-16'sd32768, 16'sd0, 16'sd0, 32'sd1, 32'sd65536, 32'sd65536}, 1'b0, '0},
    '{'{-16'sd16384, 16'sd0, 16'sd0, 32'sd5, 32'sd65536, -32'sd7}, 1'b0, '0},
    '{'{16'sd0, 16'sd16384, 16'sd0, 32'sd65536, 32'sd0, 32'sd65536}, 1'b0, '0},
    '{'{16'sd0, -16'sd32768, 16'sd0, CMIN, 32'sd0, CMAX}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd16384, CMAX, CMAX, 32'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, -16'sd32768, CMIN, CMIN, CMIN}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd8192, CMAX, CMAX, CMAX}, 1'b0, '0},
    '{'{16'sd8192, 16'sd8192, 16'sd8192, CMIN, CMIN, CMIN}, 1'b0, '0},
    '{'{16'sd32767, 16'sd32767, 16'sd32767, CMAX, CMIN, CMAX}, 1'b0, '0},
    '{'{-16'sd1, -16'sd1, -16'sd1, -32'sd1, -32'sd1, -32'sd1}, 1'b0, '0},
    '{'{16'sd1, 16'sd1, 16'sd1, 32'sd1, 32'sd1, 32'sd1}, 1'b0, '0},
    '{'{16'sh5555, -16'sh5556, 16'sh2AAA, 32'sh5555_5555, -32'sh5555_5556, 32'sh1234_5678},
      1'b0, '0},
    '{'{16'sd16383, 16'sd16385, -16'sd16383, 32'sh7FFF_0000, 32'sh0000_FFFF, -32'sd65536},
      1'b0, '0}
  };

  initial begin
    int left;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].result);
      if ($urandom_range(0, 3) == 0) take_break();
    end
    vec_valid <= 1'b0;
    while (pending_rots.size() != 0) @(negedge clk);
    long_hold = 1'b1;
    for (int i = 0; i < 80; i++) send_word(random_word(), 1'b0, '0);
    long_hold = 1'b0;
    left = N_RANDOM - 80;
    while (left > 0) begin
      for (int b = $urandom_range(1, 30); b > 0 && left > 0; b--) begin
        send_word(random_word(), 1'b0, '0);
        left--;
      end
      if ($urandom_range(0, 2) != 0) take_break();
    end
    vec_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // The receiver stalls on its own pattern and holds off for one long stretch.
  initial begin
    int hold;
    int phase;
    @(negedge clk);
    phase = 0;
    forever begin
      @(negedge clk);
      if (long_hold && hold == 0) begin
        rot_ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold = 1;
      end
      phase++;
      if (phase % 200 < 60) rot_ready <= 1'b1;
      else rot_ready <= ($urandom_range(0, 9) > 3);
    end
  end

  always @(posedge clk) begin
    rot_word_t want;
    if (!rst && rot_valid && rot_ready) begin
      if (pending_rots.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time, rot_x, rot_y, rot_z);
        error_count++;
      end else begin
        want = pending_rots.pop_front();
        if (rot_x !== want.x) begin
          $display("%0t: rot_x expected %0d actual %0d", $time, want.x, rot_x);
          error_count++;
        end
        if (rot_y !== want.y) begin
          $display("%0t: rot_y expected %0d actual %0d", $time, want.y, rot_y);
          error_count++;
        end
        if (rot_z !== want.z) begin
          $display("%0t: rot_z expected %0d actual %0d", $time, want.z, rot_z);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((vec_valid && vec_ready) || (rot_valid && rot_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stimulus_done);
    fork
      begin
        while (pending_rots.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
      end
      begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
      end
    join_any
    if (pending_rots.size() == 0 && error_count == 0 && idle_cycles < WATCHDOG_LIMIT) begin
      $display("euler_vector_rotation_core_tb: done, clean");
    end else begin
      $display("euler_vector_rotation_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT || !(1'b1)) @(posedge clk);
    if (!stimulus_done) begin
      $display("euler_vector_rotation_core_tb: done, errors");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/evr_pkg.sv
rtl/evr_trig.sv
rtl/evr_rot.sv
rtl/euler_vector_rotation_core.sv
tb/euler_vector_rotation_core_tb.sv
